// ===== rtl/graph_depth_first_walk_assert.svh =====
// Assertion macros shared by the depth-first walk modules.
// Each macro expands to one labelled concurrent assertion clocked on clk with arst_n.
`ifndef GRAPH_DEPTH_FIRST_WALK_ASSERT_SVH
`define GRAPH_DEPTH_FIRST_WALK_ASSERT_SVH

// The antecedent implies the consequent in the same cycle.
`define GDFW_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define GDFW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// The condition never holds.
`define GDFW_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

// ===== rtl/gdfw_pkg.sv =====
// Shared types, constants and helper functions for the depth-first walk block.
// Used by gdfw_ctrl, gdfw_dp and graph_depth_first_walk; depends on nothing.
package gdfw_pkg;

	localparam int MAX_VERTICES = 16;
	localparam int VIDX_W       = 4;
	localparam int VNUM_W       = 5;
	localparam int IN_DATA_W    = 32;
	localparam int OUT_DATA_W   = 8;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_START = 1'b1;

	localparam logic [VNUM_W-1:0] COUNT_RESET = 5'd16;

	typedef struct packed {
		logic load_row;
		logic start;
		logic step;
		logic emit_err;
	} gdfw_cmd_t;

	typedef struct packed {
		logic start_ok;
		logic found;
		logic depth_one;
		logic depth_empty;
		logic out_free;
	} gdfw_sts_t;

	// Encodes a one-hot vertex mask into its zero-based index.
	function automatic logic [VIDX_W-1:0] onehot_index(input logic [MAX_VERTICES-1:0] onehot);
		logic [VIDX_W-1:0] idx;
		idx = '0;
		for (int i = 0; i < MAX_VERTICES; i++) begin
			idx = idx | ({VIDX_W{onehot[i]}} & VIDX_W'(i));
		end
		return idx;
	endfunction

endpackage

// ===== rtl/gdfw_ctrl.sv =====
// Controller state machine of the depth-first walk: input handshake and walk sequencing.
// Depends on gdfw_pkg; drives gdfw_dp through command and status structs.
module gdfw_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic              op,
	input  gdfw_pkg::gdfw_sts_t sts,
	output gdfw_pkg::gdfw_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_ERR  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		cmd          = '0;
		state_d      = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (op == gdfw_pkg::OP_LOAD) begin
						cmd.load_row = 1'b1;
					end else if (sts.start_ok) begin
						cmd.start = 1'b1;
						state_d   = ST_WALK;
					end else begin
						state_d = ST_ERR;
					end
				end
			end
			ST_WALK: begin
				// One stack step per cycle, held while the output word is still waiting.
				if (sts.out_free) begin
					cmd.step = 1'b1;
					if (!sts.found && sts.depth_one) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_ERR: begin
				if (sts.out_free) begin
					cmd.emit_err = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`include "graph_depth_first_walk_assert.svh"

	`GDFW_ASSERT_NEVER(a_walk_has_stack, (state_q == ST_WALK) && sts.depth_empty, "walk with empty stack")
	`GDFW_ASSERT_NEXT(a_err_leaves_idle, accept && (op == gdfw_pkg::OP_START) && !sts.start_ok, state_q == ST_ERR, "bad start not flagged")

endmodule

// ===== rtl/gdfw_dp.sv =====
// Datapath of the depth-first walk: adjacency rows, visited map, vertex stack and output word.
// Depends on gdfw_pkg; sequenced by gdfw_ctrl through command and status structs.
module gdfw_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wen,
	input  logic [gdfw_pkg::VNUM_W-1:0]        cfg_wdata,
	input  logic [gdfw_pkg::IN_DATA_W-1:0]     s_tdata,
	input  gdfw_pkg::gdfw_cmd_t                cmd,
	output gdfw_pkg::gdfw_sts_t                sts,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [gdfw_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic                               m_tuser,
	output logic                               m_tlast
);

	localparam int NV = gdfw_pkg::MAX_VERTICES;
	localparam int IW = gdfw_pkg::VIDX_W;
	localparam int CW = gdfw_pkg::VNUM_W;

	logic [CW-1:0] count_q;
	logic [NV-1:0] adj_q [NV];
	logic [NV-1:0] visited_q;
	logic [IW-1:0] stack_q [NV];
	logic [CW-1:0] depth_q;
	logic [CW-1:0] pend_q;

	logic          out_valid_q;
	logic [CW-1:0] out_vertex_q;
	logic          out_err_q;
	logic          out_last_q;

	logic [IW-1:0] row_index;
	logic [NV-1:0] row_bits;
	logic [CW-1:0] start_vertex;
	logic [CW-1:0] eff_count;
	logic [NV-1:0] count_mask;
	logic [CW-1:0] depth_m1;
	logic [IW-1:0] top_idx;
	logic [NV-1:0] cand;
	logic [NV-1:0] pick;
	logic [IW-1:0] next_idx;
	logic          found;
	logic          depth_one;
	logic          step_emit;

	assign row_index    = s_tdata[3:0];
	assign row_bits     = s_tdata[19:4];
	assign start_vertex = s_tdata[24:20];

	assign eff_count = (count_q > CW'(NV)) ? CW'(NV) : count_q;

	always_comb begin
		for (int i = 0; i < NV; i++) begin
			count_mask[i] = (CW'(i) < eff_count);
		end
	end

	// The stack top's row, less visited and unused vertices; the lowest set bit is taken.
	assign depth_m1  = depth_q - CW'(1);
	assign top_idx   = stack_q[depth_m1[IW-1:0]];
	assign cand      = adj_q[top_idx] & ~visited_q & count_mask;
	assign pick      = cand & (~cand + NV'(1));
	assign next_idx  = gdfw_pkg::onehot_index(pick);
	assign found     = |cand;
	assign depth_one = (depth_q == CW'(1));
	assign step_emit = cmd.step && (found || depth_one);

	assign sts.start_ok    = (start_vertex != '0) && (start_vertex <= eff_count);
	assign sts.found       = found;
	assign sts.depth_one   = depth_one;
	assign sts.depth_empty = (depth_q == '0);
	assign sts.out_free    = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= gdfw_pkg::COUNT_RESET;
		end else if (cfg_wen) begin
			count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NV; i++) begin
				adj_q[i] <= '0;
			end
		end else if (cmd.load_row) begin
			adj_q[row_index] <= row_bits;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q   <= '0;
			depth_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				visited_q <= NV'(1) << start_vertex[IW-1:0] - IW'(1);
				depth_q   <= CW'(1);
			end else if (cmd.step) begin
				if (found) begin
					visited_q <= visited_q | pick;
					if (depth_q < CW'(NV)) begin
						depth_q <= depth_q + CW'(1);
					end
				end else begin
					depth_q <= depth_m1;
				end
			end
			if (step_emit || cmd.emit_err) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Stack entries and the held word are payload and need no reset.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			stack_q[0] <= start_vertex[IW-1:0] - IW'(1);
			pend_q     <= start_vertex;
		end else if (cmd.step && found) begin
			if (depth_q < CW'(NV)) begin
				stack_q[depth_q[IW-1:0]] <= next_idx;
			end
			pend_q <= CW'(next_idx) + CW'(1);
		end
		// A vertex is sent only once the next discovery or the final pop shows whether it is last.
		if (cmd.emit_err) begin
			out_vertex_q <= '0;
			out_err_q    <= 1'b1;
			out_last_q   <= 1'b1;
		end else if (step_emit) begin
			out_vertex_q <= pend_q;
			out_err_q    <= 1'b0;
			out_last_q   <= !found;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(gdfw_pkg::OUT_DATA_W - CW){1'b0}}, out_vertex_q};
	assign m_tuser  = out_err_q;
	assign m_tlast  = out_last_q;

	`include "graph_depth_first_walk_assert.svh"

	`GDFW_ASSERT_NEVER(a_depth_bound, depth_q > CW'(NV), "stack depth above vertex limit")
	`GDFW_ASSERT_NEXT(a_final_pop_last, cmd.step && !found && depth_one, m_tvalid && m_tlast, "final pop sent no last word")
	`GDFW_ASSERT_NEXT(a_start_one_visited, cmd.start, $onehot(visited_q) && (depth_q == CW'(1)), "start did not seed the walk")

endmodule

// ===== rtl/graph_depth_first_walk.sv =====
// Depth-first walk over an adjacency matrix of up to 16 vertices. A load word writes one row.
// A start word seeds the stack with its vertex; the walk then takes one stack step a cycle
// while the output word is free, each step scanning the stack top's neighbour row. The first
// step sends the start vertex. The next word is taken once the walk's last word is registered.
// Reset clears all adjacency rows, empties the stack and sets the vertex count to 16.
// Top level; depends on gdfw_pkg, gdfw_ctrl and gdfw_dp.
module graph_depth_first_walk (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [4:0]  cfg_wdata,  // vertex_count
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,    // row_index[3:0], row_bits[19:4], start_vertex[24:20]
	input  logic        s_tuser,    // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,    // visited_vertex[4:0]
	output logic        m_tuser,    // status
	output logic        m_tlast     // last
);

	gdfw_pkg::gdfw_cmd_t cmd;
	gdfw_pkg::gdfw_sts_t sts;

	gdfw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.op       (s_tuser),
		.sts      (sts),
		.cmd      (cmd)
	);

	gdfw_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
